FILE: rtl/serial_command_line_decoder_core_assert.svh
// Assertion macros shared by the serial command line decoder checkers.
// Depends on nothing; include by bare file name.
`ifndef SERIAL_COMMAND_LINE_DECODER_CORE_ASSERT_SVH
`define SERIAL_COMMAND_LINE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scld assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scld assertion failed");

`endif

FILE: rtl/scld_pkg.sv
// Package for the serial command line decoder: sizes, codes, keyword table,
// controller/datapath interface structs and byte helper functions. No dependencies.
`timescale 1ns / 1ps

package scld_pkg;

    localparam int unsigned LINE_BYTES = 64;
    localparam int unsigned FILL_W     = $clog2(LINE_BYTES + 1);

    localparam int unsigned KW_NUM  = 5;
    localparam int unsigned KW_MAX  = 8;
    localparam int unsigned HIST_N  = KW_MAX - 1;

    typedef logic [2:0] t_kind;

    localparam t_kind KIND_SINE     = 3'd0;
    localparam t_kind KIND_TRIANGLE = 3'd1;
    localparam t_kind KIND_SQUARE   = 3'd2;
    localparam t_kind KIND_RAMP     = 3'd3;
    localparam t_kind KIND_HELP     = 3'd4;
    localparam t_kind KIND_UNKNOWN  = 3'd5;
    localparam t_kind KIND_TOO_LONG = 3'd6;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] MAG_SAT = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    // Keyword bytes stored last character first, zero padded.
    localparam logic [7:0] KW_REV [KW_NUM][KW_MAX] = '{
        '{"e", "n", "i", "s", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "g", "n", "a", "i", "r", "t"},
        '{"e", "r", "a", "u", "q", "s", 8'h00, 8'h00},
        '{"p", "m", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "l", "e", "h", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam int unsigned KW_LEN [KW_NUM] = '{4, 8, 6, 4, 4};

    typedef logic [HIST_N-1:0][7:0] t_hist;

    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic eol;
    } t_status;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Match keyword k on the window that ends with byte c.
    function automatic logic kw_hit(input int unsigned k, input logic [7:0] c,
                                    input t_hist h);
        logic hit;
        logic [7:0] b;
        hit = 1'b1;
        for (int unsigned j = 0; j < KW_MAX; j++) begin
            b = (j == 0) ? c : h[(j == 0) ? 0 : j - 1];
            if ((j < KW_LEN[k]) && (b != KW_REV[k][j])) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

FILE: rtl/serial_command_line_decoder_core.sv
// Serial command line decoder: gathers received bytes into lines and reports
// the command found in each. It takes a byte in the idle state, captures the
// transaction, and folds the byte into the line state (fill count, keyword
// window, running number parse) in the work state, so no end-of-line scan is
// needed; it takes no new byte until that update is done. A line end that
// must report waits in the update cycle while the previous result still sits
// unaccepted in the output register. The result register loads at the clock
// edge that ends the update of the line end, once the output is free.
// Depends on scld_pkg, scld_ctrl and scld_datapath.
`timescale 1ns / 1ps

module serial_command_line_decoder_core
    import scld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] frequency, [32] has_number, [39:33] zero
    output logic [2:0]  m_axis_tuser    // [2:0] kind
);

    t_cmd        cmd;
    t_status     status;
    t_kind       kind;
    logic [31:0] frequency;
    logic        has_number;

    scld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    scld_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_rx_byte    (s_axis_tdata),
        .o_status     (status),
        .o_kind       (kind),
        .o_frequency  (frequency),
        .o_has_number (has_number)
    );

    assign m_axis_tdata = {7'b0, has_number, frequency};
    assign m_axis_tuser = kind;

endmodule

FILE: rtl/scld_ctrl.sv
// Controller for the serial command line decoder: sequences byte capture,
// line update and the result register valid flag. Depends on scld_pkg.
`timescale 1ns / 1ps

module scld_ctrl
    import scld_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WORK = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_WORK;
                end
            end
            ST_WORK: begin
                if (!i_status.eol) begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    o_cmd.step     = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/scld_datapath.sv
// Datapath for the serial command line decoder: fill count, keyword window,
// running number parse and the result register. Depends on scld_pkg.
`timescale 1ns / 1ps

module scld_datapath
    import scld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_rx_byte,
    output t_status     o_status,
    output t_kind       o_kind,
    output logic [31:0] o_frequency,
    output logic        o_has_number
);

    localparam logic [1:0] P_OFF   = 2'd0;
    localparam logic [1:0] P_BLANK = 2'd1;
    localparam logic [1:0] P_DIGIT = 2'd2;
    localparam logic [1:0] P_DONE  = 2'd3;

    logic [7:0]        r_byte;
    logic [FILL_W-1:0] r_fill, n_fill;
    t_hist             r_hist, n_hist;
    logic [KW_NUM-1:0] r_found, n_found;
    logic [1:0]        r_phase, n_phase;
    logic              r_neg, n_neg;
    logic [31:0]       r_mag, n_mag;

    t_kind             r_kind, n_kind;
    logic [31:0]       r_freq, n_freq;
    logic              r_has, n_has;

    logic              eol;
    logic              store;
    logic [KW_NUM-1:0] hit;
    logic [35:0]       prod;
    logic [31:0]       mag_acc;
    logic [31:0]       num;
    t_kind             kw_kind;
    logic              wave;

    assign eol   = (r_byte == CH_LF) && (r_fill != '0);
    assign store = (r_fill < FILL_W'(LINE_BYTES)) && (r_byte != CH_CR);

    always_comb begin
        for (int unsigned k = 0; k < KW_NUM; k++) begin
            hit[k] = (r_fill >= FILL_W'(KW_LEN[k] - 1)) && kw_hit(k, r_byte, r_hist);
        end
    end

    always_comb begin
        prod = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1) + {32'b0, r_byte[3:0]};
        mag_acc = (prod > {4'b0, MAG_SAT}) ? MAG_SAT : prod[31:0];
    end

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_mag   = r_mag;
        case (r_phase)
            P_OFF: begin
                if (r_byte == CH_SPACE) begin
                    n_phase = P_BLANK;
                end
            end
            P_BLANK: begin
                if (is_blank(r_byte)) begin
                    n_phase = P_BLANK;
                end else if ((r_byte == CH_PLUS) || (r_byte == CH_MINUS)) begin
                    n_neg   = (r_byte == CH_MINUS);
                    n_phase = P_DIGIT;
                end else if (is_digit(r_byte)) begin
                    n_mag   = mag_acc;
                    n_phase = P_DIGIT;
                end else begin
                    n_phase = P_DONE;
                end
            end
            P_DIGIT: begin
                if (is_digit(r_byte)) begin
                    n_mag = mag_acc;
                end else begin
                    n_phase = P_DONE;
                end
            end
            default: begin
                n_phase = P_DONE;
            end
        endcase
    end

    always_comb begin
        kw_kind = KIND_UNKNOWN;
        for (int k = KW_NUM - 1; k >= 0; k--) begin
            if (r_found[k]) begin
                kw_kind = t_kind'(k);
            end
        end
        wave = (kw_kind <= KIND_RAMP);
        num  = r_neg ? (32'd0 - r_mag) : ((r_mag > POS_MAX) ? POS_MAX : r_mag);
    end

    always_comb begin
        n_fill  = r_fill;
        n_hist  = r_hist;
        n_found = r_found;
        n_kind  = r_kind;
        n_freq  = r_freq;
        n_has   = r_has;
        if (i_cmd.out_load) begin
            if (r_fill >= FILL_W'(LINE_BYTES)) begin
                n_kind = KIND_TOO_LONG;
                n_freq = '0;
                n_has  = 1'b0;
            end else begin
                n_kind = kw_kind;
                n_has  = wave && (r_phase != P_OFF);
                n_freq = (wave && (r_phase != P_OFF)) ? num : '0;
            end
        end
        if (i_cmd.step && !eol && store) begin
            n_fill  = r_fill + FILL_W'(1);
            n_hist  = {r_hist[HIST_N-2:0], r_byte};
            n_found = r_found | hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_rx_byte;
        end
        r_hist <= n_hist;
        r_kind <= n_kind;
        r_freq <= n_freq;
        r_has  <= n_has;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_found <= '0;
            r_phase <= P_OFF;
            r_neg   <= 1'b0;
            r_mag   <= '0;
        end else if (i_cmd.step && eol) begin
            r_fill  <= '0;
            r_found <= '0;
            r_phase <= P_OFF;
            r_neg   <= 1'b0;
            r_mag   <= '0;
        end else begin
            r_fill  <= n_fill;
            r_found <= n_found;
            if (i_cmd.step && store) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_mag   <= n_mag;
            end
        end
    end

    assign o_status.eol = eol;
    assign o_kind       = r_kind;
    assign o_frequency  = r_freq;
    assign o_has_number = r_has;

endmodule

FILE: rtl/scld_checker.sv
// Port-level checker for the serial command line decoder, bound to the top
// level. Depends on scld_pkg and serial_command_line_decoder_core_assert.svh.
`timescale 1ns / 1ps
`include "serial_command_line_decoder_core_assert.svh"

module scld_checker
    import scld_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    logic        in_txn;
    logic        no_number;
    logic        out_held;
    logic [42:0] out_word;

    assign in_txn    = s_axis_tvalid && s_axis_tready;
    assign no_number = (m_axis_tuser == KIND_HELP) || (m_axis_tuser == KIND_UNKNOWN)
                       || (m_axis_tuser == KIND_TOO_LONG) || !m_axis_tdata[32];
    assign out_held  = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tuser, m_axis_tdata};

    `SCLD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, m_axis_tvalid && $stable(out_word))
    `SCLD_ASSERT_NOW(a_kind_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser <= KIND_TOO_LONG)
    `SCLD_ASSERT_NOW(a_no_number_zero, i_clk, i_rst_n, m_axis_tvalid && no_number, m_axis_tdata[32:0] == 33'd0)
    `SCLD_ASSERT_NOW(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[39:33] == 7'd0)
    `SCLD_ASSERT_NEXT(a_one_byte_at_once, i_clk, i_rst_n, in_txn, !s_axis_tready)

endmodule

bind serial_command_line_decoder_core scld_checker u_scld_checker (.*);
